// ===== design/bmsp_pkg.sv =====
package bmsp_pkg;

   localparam int unsigned MaxVerticesDefault = 5000000;
   localparam int unsigned MaxFacesDefault    = 5000000;
   localparam int unsigned CountWidth         = 23;

   typedef enum logic [2:0] {
      PH_TAG     = 3'd0,
      PH_NEWLINE = 3'd1,
      PH_HEADER  = 3'd2,
      PH_HSKIP   = 3'd3,
      PH_VERTS   = 3'd4,
      PH_FACES   = 3'd5,
      PH_DRAIN   = 3'd6
   } phase_type;

   typedef enum logic [1:0] {
      KIND_POSITION = 2'd0,
      KIND_INDEX    = 2'd1,
      KIND_SUCCESS  = 2'd2,
      KIND_FAILURE  = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NONE      = 3'd0,
      ERR_VERSION   = 3'd1,
      ERR_TEXT      = 3'd2,
      ERR_TRUNCATED = 3'd3,
      ERR_SIZES     = 3'd4,
      ERR_INDEX     = 3'd5
   } err_type;

   typedef struct packed {
      logic [1:0]  out_kind;
      logic [31:0] out_value;
      logic [1:0]  out_component;
      logic [2:0]  error_code;
      logic        last_result;
   } rsp_type;

   // Work produced by one byte: up to two results.
   typedef struct packed {
      logic    valid0;
      rsp_type rsp0;
      logic    valid1;
      rsp_type rsp1;
   } work_type;

   localparam logic [63:0] TagPrefix = 64'h206e_6f69_7372_6576; // "version " LE

   function automatic logic [7:0] prefix_byte(input logic [2:0] idx);
      prefix_byte = TagPrefix[idx*8 +: 8];
   endfunction

   // Little-endian tails "X.YZ"; returns 8 on no match.
   function automatic logic [3:0] tag_lookup(input logic [31:0] w);
      logic [3:0] r;
      r = 4'd8;
      case (w)
         32'h3030_2E31: r = 4'd0;
         32'h3130_2E31: r = 4'd1;
         32'h3030_2E32: r = 4'd2;
         32'h3030_2E33: r = 4'd3;
         32'h3130_2E33: r = 4'd4;
         32'h3030_2E34: r = 4'd5;
         32'h3130_2E34: r = 4'd6;
         32'h3030_2E35: r = 4'd7;
         default:       r = 4'd8;
      endcase
      tag_lookup = r;
   endfunction

endpackage

// ===== design/bmsp_req_if.sv =====
interface bmsp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_file;
   modport source (output valid, data_byte, end_of_file, input ready);
   modport sink   (input valid, data_byte, end_of_file, output ready);
endinterface

// ===== design/bmsp_rsp_if.sv =====
interface bmsp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  out_kind;
   logic [31:0] out_value;
   logic [1:0]  out_component;
   logic [2:0]  error_code;
   logic        last_result;
   modport source (output valid, out_kind, out_value, out_component, error_code,
                   last_result, input ready);
   modport sink   (input valid, out_kind, out_value, out_component, error_code,
                   last_result, output ready);
endinterface

// ===== design/bmsp_front.sv =====
module bmsp_front
   import bmsp_pkg::*;
#(
   parameter int unsigned MAX_VERTICES = MaxVerticesDefault,
   parameter int unsigned MAX_FACES    = MaxFacesDefault
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  logic [7:0] in_byte,
   input  logic     in_eof,
   output logic     work_valid,
   output work_type work,
   input  logic     work_space
);
   localparam logic [31:0] MaxV = 32'(MAX_VERTICES);
   localparam logic [31:0] MaxF = 32'(MAX_FACES);

   phase_type              phase_ff, phase_in;
   logic [15:0]            bcnt_ff, bcnt_in;
   logic [2:0]             ver_ff, ver_in;
   logic [15:0]            hlen_ff, hlen_in;
   logic [7:0]             vstr_ff, vstr_in, fstr_ff, fstr_in;
   logic [CountWidth-1:0]  vtot_ff, vtot_in, ftot_ff, ftot_in, rec_ff, rec_in;
   logic [31:0]            ws_ff, ws_in;
   logic                   sent_ff, sent_in;

   logic        take;
   logic [15:0] k, fl, k1;
   logic [2:0]  fail;
   logic        succ;
   logic [3:0]  found;
   logic [CountWidth-1:0] rec1;
   logic [16:0] skip_lim;
   logic        hdr;
   logic [1:0]  comp;
   rsp_type     data_r, stat_r, eof_r;
   logic        data_v;

   assign in_ready = work_space;
   assign take     = in_valid && work_space;

   always_comb begin
      phase_in = phase_ff; bcnt_in = bcnt_ff; ver_in = ver_ff; hlen_in = hlen_ff;
      vstr_in = vstr_ff; fstr_in = fstr_ff; vtot_in = vtot_ff; ftot_in = ftot_ff;
      rec_in = rec_ff; sent_in = sent_ff;
      fail = ERR_NONE; succ = 1'b0; data_v = 1'b0; comp = 2'd0; hdr = 1'b0;
      data_r = '0; found = 4'd8; rec1 = rec_ff + 1'b1; skip_lim = '0;
      k = bcnt_ff; k1 = bcnt_ff + 16'd1;
      ws_in = (phase_ff == PH_HEADER || phase_ff == PH_VERTS || phase_ff == PH_FACES)
              ? {in_byte, ws_ff[31:8]} : ws_ff;
      fl = (ver_ff == 3'd2) ? 16'd12 : 16'd16;
      unique case (phase_ff)
         PH_TAG: begin
            if (k < 16'd8) begin
               if (in_byte != prefix_byte(k[2:0])) fail = ERR_VERSION;
               bcnt_in = k1;
            end else begin
               ws_in = {in_byte, ws_ff[31:8]};
               if (k >= 16'd11) begin
                  found = tag_lookup(ws_in);
                  if (found == 4'd8) fail = ERR_VERSION;
                  else if (found < 4'd2) begin
                     ver_in = found[2:0];
                     fail = in_eof ? ERR_TRUNCATED : ERR_TEXT;
                  end else begin
                     ver_in = found[2:0]; phase_in = PH_NEWLINE; bcnt_in = '0;
                  end
               end else bcnt_in = k1;
            end
         end
         PH_NEWLINE: begin
            if (in_byte != 8'h0D && in_byte != 8'h0A) begin
               ws_in = {in_byte, 24'd0}; phase_in = PH_HEADER; k = '0; k1 = 16'd1;
               hdr = 1'b1;
            end
         end
         PH_HEADER: hdr = 1'b1;
         PH_HSKIP: begin
            bcnt_in = k1;
            skip_lim = {1'b0, hlen_ff} - {1'b0, fl};
            if ({1'b0, k1} >= skip_lim) begin bcnt_in = '0; phase_in = PH_VERTS; end
         end
         PH_VERTS: begin
            if (k < 16'd12) begin
               comp = k[3:2];
               if (k[1:0] == 2'b11) begin
                  data_v = 1'b1;
                  data_r = '{KIND_POSITION, ws_in, comp, ERR_NONE, 1'b0};
               end
            end
            if ({8'd0, k1} >= {16'd0, vstr_ff}) begin
               bcnt_in = '0; rec_in = rec1;
               if (rec1 >= vtot_ff) begin rec_in = '0; phase_in = PH_FACES; end
            end else bcnt_in = k1;
         end
         PH_FACES: begin
            comp = k[3:2];
            if (k[1:0] == 2'b11 && ws_in >= {9'd0, vtot_ff}) fail = ERR_INDEX;
            else begin
               if (k[1:0] == 2'b11) begin
                  data_v = 1'b1;
                  data_r = '{KIND_INDEX, ws_in, comp, ERR_NONE, 1'b0};
               end
               if (k >= 16'd11) begin
                  bcnt_in = '0; rec_in = rec1;
                  if (rec1 >= ftot_ff) succ = 1'b1;
               end else bcnt_in = k1;
            end
         end
         PH_DRAIN: ;
         default: ;
      endcase
      if (hdr) begin
         if (k == 16'd0) hlen_in = {8'd0, in_byte};
         else if (k == 16'd1) hlen_in = {in_byte, hlen_ff[7:0]};
         else if (k == 16'd2) vstr_in = in_byte;
         else if (k == 16'd3) fstr_in = in_byte;
         if (k == ((ver_ff == 3'd2) ? 16'd7 : 16'd11))
            vtot_in = (ws_in == 32'd0 || ws_in > MaxV) ? '0 : ws_in[CountWidth-1:0];
         if (k1 >= fl) begin
            ftot_in = (ws_in == 32'd0 || ws_in > MaxF) ? '0 : ws_in[CountWidth-1:0];
            if (vstr_in < 8'd12 || fstr_in != 8'd12 || vtot_in == '0 || ftot_in == '0)
               fail = ERR_SIZES;
            else begin
               bcnt_in = '0; rec_in = '0;
               phase_in = (hlen_in > fl) ? PH_HSKIP : PH_VERTS;
            end
         end else bcnt_in = k1;
      end
      stat_r = '0; eof_r = '0;
      if (fail != ERR_NONE && !sent_ff) begin
         stat_r = '{KIND_FAILURE, 32'd0, 2'd0, fail, in_eof};
         sent_in = 1'b1; phase_in = PH_DRAIN;
      end else if (succ && !sent_ff) begin
         stat_r = '{KIND_SUCCESS, 32'd0, 2'd0, ERR_NONE, in_eof};
         sent_in = 1'b1; phase_in = PH_DRAIN;
      end
      eof_r = '{KIND_FAILURE, 32'd0, 2'd0, ERR_TRUNCATED, 1'b1};
      // Pack at most two results, in order: data word, then status or eof status.
      work = '0;
      if (data_v) begin work.valid0 = 1'b1; work.rsp0 = data_r; end
      if (sent_in && !sent_ff) begin
         if (data_v) begin work.valid1 = 1'b1; work.rsp1 = stat_r; end
         else begin work.valid0 = 1'b1; work.rsp0 = stat_r; end
      end else if (in_eof && !sent_ff) begin
         if (data_v) begin work.valid1 = 1'b1; work.rsp1 = eof_r; end
         else begin work.valid0 = 1'b1; work.rsp0 = eof_r; end
      end
      work_valid = take && work.valid0;
   end

   always_ff @(posedge clock) begin
      if (reset || (take && in_eof)) begin
         phase_ff <= PH_TAG; bcnt_ff <= '0; ver_ff <= '0; hlen_ff <= '0;
         vstr_ff <= '0; fstr_ff <= '0; vtot_ff <= '0; ftot_ff <= '0; rec_ff <= '0;
         ws_ff <= '0; sent_ff <= 1'b0;
      end else if (take) begin
         phase_ff <= phase_in; bcnt_ff <= bcnt_in; ver_ff <= ver_in; hlen_ff <= hlen_in;
         vstr_ff <= vstr_in; fstr_ff <= fstr_in; vtot_ff <= vtot_in; ftot_ff <= ftot_in;
         rec_ff <= rec_in; ws_ff <= ws_in; sent_ff <= sent_in;
      end
   end

   a_drain_sent: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DRAIN |-> sent_ff) else $error("drain without status");
   a_two_needs_one: assert property (@(posedge clock) disable iff (reset)
      work.valid1 |-> work.valid0) else $error("second result without first");
   a_tag_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_TAG |-> bcnt_ff <= 16'd11) else $error("tag count overrun");
endmodule

// ===== design/bmsp_queue.sv =====
module bmsp_queue
   import bmsp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  work_type push_data,
   output logic     space,
   output logic     pop_valid,
   output work_type pop_data,
   input  logic     pop
);
   localparam int Depth = 4;
   work_type        mem_ff [Depth];
   logic [1:0]      wp_ff, rp_ff;
   logic [2:0]      cnt_ff;

   assign space     = cnt_ff < 3'(Depth);
   assign pop_valid = cnt_ff != 3'd0;
   assign pop_data  = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 2'd1;
         if (pop)  rp_ff <= rp_ff + 2'd1;
         cnt_ff <= cnt_ff + {2'd0, push} - {2'd0, pop};
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> space) else $error("queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> pop_valid) else $error("queue underflow");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 3'(Depth)) else $error("queue count out of range");
endmodule

// ===== design/bmsp_back.sv =====
module bmsp_back
   import bmsp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     work_valid,
   input  work_type work,
   output logic     work_pop,
   output logic     out_valid,
   output rsp_type  out_data,
   input  logic     out_ready
);
   logic    second_ff, second_in;
   logic    ov_ff, ov_in;
   rsp_type od_ff, od_in;
   logic    load;

   always_comb begin
      second_in = second_ff; ov_in = ov_ff; od_in = od_ff; work_pop = 1'b0;
      load = !ov_ff || out_ready;
      if (load) begin
         ov_in = 1'b0;
         if (work_valid) begin
            ov_in = 1'b1;
            if (second_ff) begin
               od_in = work.rsp1; second_in = 1'b0; work_pop = 1'b1;
            end else begin
               od_in = work.rsp0;
               if (work.valid1) second_in = 1'b1;
               else work_pop = 1'b1;
            end
         end
      end
   end

   assign out_valid = ov_ff;
   assign out_data  = od_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0; second_ff <= 1'b0;
      end else begin
         ov_ff <= ov_in; second_ff <= second_in;
      end
   end
   always_ff @(posedge clock) od_ff <= od_in;

   a_second_needs_work: assert property (@(posedge clock) disable iff (reset)
      second_ff |-> work_valid) else $error("second half without entry");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      ov_ff && !out_ready |=> ov_ff && $stable(od_ff)) else $error("result lost");
endmodule

// ===== design/binary_mesh_stream_parser_unit.sv =====
// Binary mesh stream parser.
// req channel: one file byte per request, with end_of_file on the last byte.
// rsp channel: position words, vertex indices and one final status per file.
// A front stage decodes each byte in the cycle it is accepted (tag match,
// header fields, record counters) and pushes up to two results as one entry
// into a four-entry queue. A back stage unpacks the entry into a registered
// output. One byte is accepted per cycle while the queue has room; a result
// passes through the queue and the output register after its byte. A byte
// that yields two results (a data word plus a status) holds its entry in the
// back stage until both are sent, so the byte rate is limited only by output draining.
// When the receiver stalls, the output register holds, the queue fills and
// req_ready drops once all four entries are in use.
// Reset clears the parse state, the queue and the output valid; the block
// then waits for the tag of a new file. The byte that ends a file also
// returns the parse state to its reset value.
module binary_mesh_stream_parser_unit
   import bmsp_pkg::*;
#(
   parameter int unsigned MAX_VERTICES = MaxVerticesDefault,
   parameter int unsigned MAX_FACES    = MaxFacesDefault
) (
   input logic         clock,
   input logic         reset,
   bmsp_req_if.sink    req,
   bmsp_rsp_if.source  rsp
);
   logic     fw_valid, q_space, q_valid, q_pop;
   work_type fw_data, q_data;
   rsp_type  out_data;

   // decode bytes, build result entries
   bmsp_front #(.MAX_VERTICES(MAX_VERTICES), .MAX_FACES(MAX_FACES)) u_front (
      .clock(clock), .reset(reset),
      .in_valid(req.valid), .in_ready(req.ready),
      .in_byte(req.data_byte), .in_eof(req.end_of_file),
      .work_valid(fw_valid), .work(fw_data), .work_space(q_space));

   // decouple decode from output stalls
   bmsp_queue u_queue (
      .clock(clock), .reset(reset), .push(fw_valid), .push_data(fw_data),
      .space(q_space), .pop_valid(q_valid), .pop_data(q_data), .pop(q_pop));

   // unpack entries to single results
   bmsp_back u_back (
      .clock(clock), .reset(reset), .work_valid(q_valid), .work(q_data),
      .work_pop(q_pop), .out_valid(rsp.valid), .out_data(out_data),
      .out_ready(rsp.ready));

   assign rsp.out_kind      = out_data.out_kind;
   assign rsp.out_value     = out_data.out_value;
   assign rsp.out_component = out_data.out_component;
   assign rsp.error_code    = out_data.error_code;
   assign rsp.last_result   = out_data.last_result;
endmodule

// ===== test/binary_mesh_stream_parser_unit_test.sv =====
`timescale 1ns / 1ps

module binary_mesh_stream_parser_unit_test;
   import bmsp_pkg::*;

   localparam int unsigned IdleLimit = 5000;
   localparam int unsigned HoldCycles = 80;
   localparam logic [7:0] ByteCr = 8'h0D;
   localparam logic [7:0] ByteLf = 8'h0A;

   logic clock;
   logic reset;

   bmsp_req_if req_ch ();
   bmsp_rsp_if rsp_ch ();

   binary_mesh_stream_parser_unit dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   // Tag text: "version " followed by one of eight tails, ordered by version code.
   logic [7:0]  tag_head [8] = '{"v", "e", "r", "s", "i", "o", "n", " "};
   logic [31:0] tag_tail [8] = '{"00.1", "10.1", "00.2", "00.3", "10.3", "00.4",
                                 "10.4", "00.5"};

   // Parser state mirrored by the predictor.
   phase_type   ps_phase;
   logic [31:0] ps_count, ps_version, ps_hlen, ps_vstride, ps_fstride;
   logic [31:0] ps_vtotal, ps_ftotal, ps_records, ps_shift;
   logic [1:0]  ps_corner;
   logic        ps_sent;

   rsp_type     pending_results [$];
   logic [7:0]  file_bytes [$];

   int unsigned bytes_sent, results_seen, files_sent, mismatches, idle_cycles;
   int unsigned status_seen;
   bit          sender_busy_mode;
   bit          hold_request;

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   task automatic clear_parse_state();
      ps_phase   = PH_TAG;
      ps_count   = '0;
      ps_version = '0;
      ps_hlen    = '0;
      ps_vstride = '0;
      ps_fstride = '0;
      ps_vtotal  = '0;
      ps_ftotal  = '0;
      ps_records = '0;
      ps_shift   = '0;
      ps_corner  = '0;
      ps_sent    = 1'b0;
   endtask

   function automatic rsp_type make_rsp(kind_type kind, logic [31:0] value,
                                        logic [1:0] corner, err_type err, logic last);
      rsp_type r;
      r.out_kind      = kind;
      r.out_value     = value;
      r.out_component = corner;
      r.error_code    = err;
      r.last_result   = last;
      return r;
   endfunction

   // Work out the results that one accepted byte causes and queue them.
   task automatic predict_byte(input logic [7:0] b, input logic eof);
      rsp_type     res [$];
      logic [31:0] k, fixed_len, nv_end;
      err_type     fail;
      bit          done_ok, in_header, nf_ok;
      int          status_at, found;
      k = ps_count;
      fail = ERR_NONE;
      done_ok = 0;
      status_at = -1;
      in_header = (ps_phase == PH_HEADER);
      if (ps_phase >= PH_HEADER && ps_phase != PH_HSKIP && ps_phase != PH_DRAIN)
         ps_shift = {b, ps_shift[31:8]};
      case (ps_phase)
         PH_TAG: begin
            if (k < 8) begin
               if (b != tag_head[k[2:0]]) fail = ERR_VERSION;
               ps_count = k + 1;
            end else begin
               ps_shift = {b, ps_shift[31:8]};
               if (k >= 11) begin
                  found = 8;
                  for (int i = 7; i >= 0; i--)
                     if (tag_tail[i] == ps_shift) found = i;
                  if (found == 8) begin
                     fail = ERR_VERSION;
                  end else if (found < 2) begin
                     ps_version = found;
                     fail = eof ? ERR_TRUNCATED : ERR_TEXT;
                  end else begin
                     ps_version = found;
                     ps_phase = PH_NEWLINE;
                     ps_count = 0;
                  end
               end else begin
                  ps_count = k + 1;
               end
            end
         end
         PH_NEWLINE: begin
            // the first byte that is not a line break opens the header
            if (b != ByteCr && b != ByteLf) begin
               ps_shift = {b, 24'd0};
               ps_phase = PH_HEADER;
               k = 0;
               in_header = 1;
            end
         end
         PH_HSKIP: begin
            ps_count = k + 1;
            if (ps_count >= ps_hlen - ((ps_version == 2) ? 12 : 16)) begin
               ps_count = 0;
               ps_phase = PH_VERTS;
            end
         end
         PH_VERTS: begin
            if (k < 12) begin
               ps_corner = k[3:2];
               if (k[1:0] == 2'd3)
                  res = {res, make_rsp(KIND_POSITION, ps_shift, ps_corner, ERR_NONE, 1'b0)};
            end
            if (k + 1 >= ps_vstride) begin
               ps_count = 0;
               ps_records++;
               if (ps_records >= ps_vtotal) begin
                  ps_records = 0;
                  ps_phase = PH_FACES;
               end
            end else begin
               ps_count = k + 1;
            end
         end
         PH_FACES: begin
            ps_corner = k[3:2];
            if (k[1:0] == 2'd3) begin
               if (ps_shift >= ps_vtotal) fail = ERR_INDEX;
               else res = {res, make_rsp(KIND_INDEX, ps_shift, ps_corner, ERR_NONE, 1'b0)};
            end
            if (fail == ERR_NONE) begin
               if (k >= 11) begin
                  ps_count = 0;
                  ps_records++;
                  if (ps_records >= ps_ftotal) done_ok = 1;
               end else begin
                  ps_count = k + 1;
               end
            end
         end
         default: ;
      endcase
      if (in_header) begin
         fixed_len = (ps_version == 2) ? 12 : 16;
         nv_end = (ps_version == 2) ? 7 : 11;
         case (k)
            0: ps_hlen = {24'd0, b};
            1: ps_hlen = ps_hlen | {16'd0, b, 8'd0};
            2: ps_vstride = {24'd0, b};
            3: ps_fstride = {24'd0, b};
            default: ;
         endcase
         if (k == nv_end)
            ps_vtotal = (ps_shift == 0 || ps_shift > MaxVerticesDefault) ? 0 : ps_shift;
         if (k + 1 >= fixed_len) begin
            nf_ok = ps_shift != 0 && ps_shift <= MaxFacesDefault;
            ps_ftotal = nf_ok ? ps_shift : 0;
            if (ps_vstride < 12 || ps_fstride != 12 || ps_vtotal == 0 || !nf_ok) begin
               fail = ERR_SIZES;
            end else begin
               ps_count = 0;
               ps_records = 0;
               ps_phase = (ps_hlen > fixed_len) ? PH_HSKIP : PH_VERTS;
            end
         end else begin
            ps_count = k + 1;
         end
      end
      if (fail != ERR_NONE && !ps_sent) begin
         status_at = res.size();
         res = {res, make_rsp(KIND_FAILURE, 32'd0, 2'd0, fail, 1'b0)};
         ps_sent = 1;
         ps_phase = PH_DRAIN;
      end else if (done_ok && !ps_sent) begin
         status_at = res.size();
         res = {res, make_rsp(KIND_SUCCESS, 32'd0, 2'd0, ERR_NONE, 1'b0)};
         ps_sent = 1;
         ps_phase = PH_DRAIN;
      end
      if (eof) begin
         if (!ps_sent) res = {res, make_rsp(KIND_FAILURE, 32'd0, 2'd0, ERR_TRUNCATED, 1'b1)};
         else if (status_at >= 0) res[status_at].last_result = 1;
         clear_parse_state();
      end
      foreach (res[i]) pending_results = {pending_results, res[i]};
   endtask

   // Send one request: idle for a random gap (none in busy mode), then hold until accepted.
   task automatic send_byte(input logic [7:0] b, input logic eof);
      int unsigned gap;
      gap = sender_busy_mode ? 0 : $urandom_range(0, 3);
      @(negedge clock);
      repeat (gap) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.data_byte   <= b;
      req_ch.end_of_file <= eof;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_byte(b, eof);
      bytes_sent++;
   endtask

   task automatic send_file();
      foreach (file_bytes[i]) send_byte(file_bytes[i], i == file_bytes.size() - 1);
      files_sent++;
   endtask

   task automatic add_byte(input logic [7:0] b);
      file_bytes = {file_bytes, b};
   endtask

   task automatic add_word(input logic [31:0] w);
      for (int i = 0; i < 4; i++) add_byte(w[i*8 +: 8]);
   endtask

   // Build a file: tag, line breaks, header, skipped header tail, records.
   task automatic build_file(input int ver, input int breaks, input int hlen, input int vs,
                             input int fs, input logic [31:0] nv, input logic [31:0] nf,
                             input bit bad_index);
      int fixed_len;
      file_bytes.delete();
      fixed_len = (ver == 2) ? 12 : 16;
      foreach (tag_head[i]) add_byte(tag_head[i]);
      add_word(tag_tail[ver]);
      repeat (breaks) add_byte($urandom_range(0, 1) ? ByteCr : ByteLf);
      // first header byte must not look like a line break or it is dropped
      add_byte((hlen[7:0] == ByteCr || hlen[7:0] == ByteLf) ? 8'd0 : hlen[7:0]);
      add_byte(hlen[15:8]);
      add_byte(vs[7:0]);
      add_byte(fs[7:0]);
      if (ver != 2) add_word($urandom);
      add_word(nv);
      add_word(nf);
      for (int i = fixed_len; i < hlen; i++) add_byte(8'($urandom_range(0, 255)));
      if (nv <= 8 && nf <= 8) begin
         repeat (nv * vs) add_byte(8'($urandom_range(0, 255)));
         for (int f = 0; f < nf; f++)
            for (int c = 0; c < 3; c++)
               add_word((bad_index && f == nf - 1 && c == 2) ? nv + $urandom_range(0, 3)
                        : $urandom_range(0, nv - 1));
      end
   endtask

   task automatic test_tags();
      // prefix mismatch, unknown tail, both text tags, text tag cut at the tag
      build_file(2, 0, 12, 12, 12, 1, 1, 0);
      file_bytes[2] = "x";
      send_file();
      build_file(3, 0, 16, 12, 12, 1, 1, 0);
      file_bytes[8] = "9";
      send_file();
      build_file(0, 0, 16, 12, 12, 1, 1, 0);
      send_file();
      build_file(1, 0, 16, 12, 12, 1, 1, 0);
      file_bytes = file_bytes[0:11];
      send_file();
   endtask

   task automatic test_headers();
      // clean files, long header and stride, bad sizes and counts, short header, cut file
      build_file(2, 2, 12, 12, 12, 1, 1, 0);
      send_file();
      build_file(7, 1, 20, 16, 12, 2, 1, 0);
      send_file();
      build_file(4, 0, 4, 12, 12, 1, 1, 0);
      send_file();
      build_file(3, 0, 16, 11, 12, 1, 1, 0);
      send_file();
      build_file(5, 0, 16, 12, 13, 1, 1, 0);
      send_file();
      build_file(6, 0, 16, 12, 12, 0, 1, 0);
      send_file();
      build_file(2, 0, 12, 12, 12, 1, MaxFacesDefault + 1, 0);
      send_file();
      build_file(3, 0, 16, 255, 12, 1, MaxFacesDefault, 0);
      file_bytes = file_bytes[0:40];
      send_file();
   endtask

   task automatic test_records();
      // out-of-range index, truncation mid-record, junk after success
      build_file(2, 0, 12, 12, 12, 2, 2, 1);
      send_file();
      build_file(3, 0, 16, 12, 12, 2, 1, 0);
      file_bytes = file_bytes[0:file_bytes.size() - 3];
      send_file();
      build_file(4, 0, 16, 12, 12, 1, 1, 0);
      repeat (3) add_byte(8'($urandom_range(0, 255)));
      send_file();
   endtask

   task automatic test_random_files();
      int ver, fixed_len, pick, cut;
      logic [31:0] nv, nf;
      while (bytes_sent < 520) begin
         sender_busy_mode = ($urandom_range(0, 4) == 0);
         pick = $urandom_range(0, 19);
         if (pick == 0) begin
            // pure noise
            file_bytes.delete();
            repeat ($urandom_range(1, 20)) add_byte(8'($urandom_range(0, 255)));
         end else begin
            ver = $urandom_range(2, 7);
            fixed_len = (ver == 2) ? 12 : 16;
            nv = $urandom_range(1, 3);
            nf = $urandom_range(1, 3);
            if (pick == 1) nv = $urandom_range(0, 1) ? 0 : MaxVerticesDefault + 1;
            build_file(ver, $urandom_range(0, 2), $urandom_range(0, fixed_len + 6),
                       (pick == 2) ? $urandom_range(0, 11) : $urandom_range(12, 16),
                       (pick == 3) ? $urandom_range(0, 255) : 12, nv, nf, pick == 4);
            if (pick == 5) file_bytes[$urandom_range(0, file_bytes.size() - 1)] =
               8'($urandom_range(0, 255));
            if (pick == 6) begin
               cut = $urandom_range(1, file_bytes.size() - 1);
               file_bytes = file_bytes[0:cut - 1];
            end
            if (pick == 7) repeat ($urandom_range(1, 4))
               add_byte(8'($urandom_range(0, 255)));
         end
         send_file();
      end
      sender_busy_mode = 0;
   endtask

   task automatic test_backpressure();
      // stall the receiver long enough that the block fills and stops taking bytes
      sender_busy_mode = 1;
      hold_request = 1;
      build_file(5, 0, 16, 12, 12, 3, 3, 0);
      send_file();
      sender_busy_mode = 0;
   endtask

   // Receiver: random ready gaps per result, plus one long hold when asked.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_ch.ready <= 1'b0;
            repeat (HoldCycles) @(negedge clock);
            hold_request = 0;
         end
         repeat (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3)) begin
            rsp_ch.ready <= 1'b0;
            @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
      end
   end

   // Compare each accepted result with the oldest prediction.
   always @(posedge clock) begin
      rsp_type got, want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = make_rsp(kind_type'(rsp_ch.out_kind), rsp_ch.out_value, rsp_ch.out_component,
                        err_type'(rsp_ch.error_code), rsp_ch.last_result);
         results_seen++;
         if (got.out_kind inside {KIND_SUCCESS, KIND_FAILURE}) status_seen++;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", got);
         end else begin
            want = pending_results.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
            end
         end
      end
   end

   // Watchdog on cycles with no handshake on either channel.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("FAILURE");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.data_byte = '0;
      req_ch.end_of_file = 1'b0;
      idle_cycles = 0;
      hold_request = 0;
      sender_busy_mode = 0;
      clear_parse_state();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_tags();
      test_headers();
      test_records();
      test_backpressure();
      test_random_files();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      mismatches += pending_results.size();
      $display("covered %0d files, %0d bytes, %0d results (%0d status)",
               files_sent, bytes_sent, results_seen, status_seen);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("FAILURE");
      end
      $finish;
   end

endmodule
